/* hdl/scns_pkg.sv */
// Package for the stick calibration block: widths, constants, channel payloads.
// No dependencies.
`default_nettype none
package scns_pkg;
  localparam int SampleW = 10;
  localparam int LevelW  = 8;
  localparam int NumFields = 4;
  localparam int DefAxes = 4;
  localparam logic [9:0] SampleMax = 10'd1023;
  localparam logic [9:0] CenterDef = 10'd512;
  localparam logic [9:0] MinSpan   = 10'd8;
  localparam logic [7:0] LevelMid  = 8'd128;
  localparam logic [2:0] RegSmooth = 3'd4;

  typedef struct packed {
    logic       button_pressed;
    logic [9:0] sample_axis0;
    logic [9:0] sample_axis1;
    logic [9:0] sample_axis2;
    logic [9:0] sample_axis3;
  } in_item_t;

  typedef struct packed {
    logic [7:0] level_axis0;
    logic [7:0] level_axis1;
    logic [7:0] level_axis2;
    logic [7:0] level_axis3;
    logic       in_calibration;
    logic       save_pulse;
  } out_item_t;

  // control from sequencer to the shared serial divider
  typedef struct packed {
    logic        start;
    logic [17:0] num;
    logic [9:0]  den;
  } div_req_t;

  typedef struct packed {
    logic       done;
    logic [17:0] quot;
  } div_rsp_t;
endpackage
`default_nettype wire

/* hdl/scns_if.sv */
// Valid/ready channel interface carrying a packed payload.
// Depends on scns_pkg only through the payload type given by the user.
`default_nettype none
interface scns_if #(parameter type payload_t = logic) (input wire logic clk);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* hdl/scns_div.sv */
// Restoring bit-serial divider, one quotient bit a cycle.
// Depends on scns_pkg.
`default_nettype none
module scns_div (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire scns_pkg::div_req_t req,
  output scns_pkg::div_rsp_t     rsp
);
  import scns_pkg::*;
  logic [17:0] quot;
  logic [10:0] rem;
  logic [9:0]  den;
  logic [4:0]  count;
  logic        busy;
  logic        done;
  logic [10:0] trial;

  always_comb trial = {rem[9:0], quot[17]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
      done  <= 1'b0;
    end else begin
      if (req.start) begin
        busy  <= 1'b1;
        count <= 5'd0;
        done  <= 1'b0;
      end else if (busy) begin
        count <= count + 5'd1;
        done  <= (count == 5'd17);
        if (count == 5'd17) begin
          busy <= 1'b0;
        end
      end else begin
        done <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quot <= req.num;
      rem  <= '0;
      den  <= req.den;
    end else if (busy) begin
      if (trial >= {1'b0, den}) begin
        rem  <= trial - {1'b0, den};
        quot <= {quot[16:0], 1'b1};
      end else begin
        rem  <= trial;
        quot <= {quot[16:0], 1'b0};
      end
    end
  end

  always_comb begin
    rsp.done = done;
    rsp.quot = quot;
  end
endmodule
`default_nettype wire

/* hdl/stick_calibrate_normalize_smooth.sv */
// Stick calibration, two-segment normalisation, trim and smoothing.
//
// Input channel: one request per tick with the button level and four 10-bit
// samples. Output channel: one result per tick with four smoothed levels,
// the calibration flag and a save pulse. Configuration: write enable, index
// and 8-bit data; index 0..3 are the signed trims, 4 the smoothing factor.
//
// Each axis goes through a shared restoring divider twice (map, then
// smoothing); a new request is taken only after the result of the last one
// has been copied into the output register.
// The divider, one quotient bit a cycle, sets the rate.
// The result sits in an output register. While the receiver stalls it holds;
// one more request is taken and worked, then the block waits with the input
// unready until the output register frees.
// Reset (synchronous, rst high) clears bounds to 0/512/1023, levels to 128,
// trims to 0 and smoothing to 3.
`default_nettype none
module stick_calibrate_normalize_smooth #(
  parameter int AXES = scns_pkg::DefAxes
) (
  input  wire logic clk,
  input  wire logic rst,
  scns_if.sink      in_ch,
  scns_if.source    out_ch,
  input  wire logic       cfg_we,
  input  wire logic [2:0] cfg_index,
  input  wire logic [7:0] cfg_data
);
  import scns_pkg::*;
  localparam int AxW = (AXES > 1) ? $clog2(AXES) : 1;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_PREP  = 7'b0000010,
    S_MAP   = 7'b0000100,
    S_MAPW  = 7'b0001000,
    S_SMO   = 7'b0010000,
    S_SMOW  = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  state_t state;
  logic [7:0] trim [NumFields];
  logic [3:0] smoothing;
  logic button_before, calibrating, save;
  logic [9:0] lo [AXES];
  logic [9:0] hi [AXES];
  logic [9:0] ce [AXES];
  logic [7:0] lvl [AXES];
  in_item_t   item;
  logic [AxW-1:0] ax;
  logic [8:0] tgt;
  logic       negd;
  div_req_t   dreq;
  div_rsp_t   drsp;
  logic       out_valid;
  logic       out_load;
  out_item_t  out_data, out_data_next;

  scns_div u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  function automatic logic [9:0] smp_of(in_item_t it, int i);
    case (i)
      0: smp_of = it.sample_axis0;
      1: smp_of = it.sample_axis1;
      2: smp_of = it.sample_axis2;
      3: smp_of = it.sample_axis3;
      default: smp_of = '0;
    endcase
  endfunction

  // current-axis map set-up
  logic [9:0] s, mn, mx, cc, sc;
  logic [7:0] tr;
  logic       upper, zero_seg;
  always_comb begin
    s  = smp_of(item, int'(ax));
    mn = lo[ax]; mx = hi[ax]; cc = ce[ax];
    if (mx <= mn) begin
      mn = '0; mx = SampleMax; cc = CenterDef;
    end
    sc = s;
    if (sc < mn) sc = mn;
    if (sc > mx) sc = mx;
    upper = sc > cc;
    zero_seg = !upper && (cc == mn);
    tr = (int'(ax) < NumFields) ? trim[2'(ax)] : 8'd0;
  end

  logic [8:0]  dlt;
  logic [9:0]  tsum;
  always_comb begin
    tsum = 10'(signed'({1'b0, drsp.quot[8:0]})) + 10'(signed'(tr));
    dlt = (tgt >= {1'b0, lvl[ax]}) ? tgt - {1'b0, lvl[ax]} : {1'b0, lvl[ax]} - tgt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NumFields; i++) trim[i] <= '0;
      smoothing <= 4'd3;
    end else if (cfg_we) begin
      if (cfg_index < RegSmooth) trim[cfg_index[1:0]] <= cfg_data;
      else if (cfg_index == RegSmooth) smoothing <= cfg_data[3:0];
    end
  end

  always_ff @(posedge clk) begin
    dreq.start <= !rst && ((state == S_MAP) || (state == S_SMO));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      button_before <= 1'b0;
      calibrating <= 1'b0;
      save <= 1'b0;
      ax <= '0;
      for (int i = 0; i < AXES; i++) begin
        lo[i] <= '0; hi[i] <= SampleMax; ce[i] <= CenterDef; lvl[i] <= LevelMid;
      end
    end else begin
      unique case (state)
        S_IDLE: if (in_ch.valid) begin
          item <= in_ch.data;
          state <= S_PREP;
        end
        S_PREP: begin
          save <= !item.button_pressed && button_before;
          if (item.button_pressed && !button_before) begin
            calibrating <= 1'b1;
            for (int i = 0; i < AXES; i++) begin
              lo[i] <= smp_of(item, i); hi[i] <= smp_of(item, i);
            end
          end else if (!item.button_pressed && button_before) begin
            for (int i = 0; i < AXES; i++) begin
              if (hi[i] <= lo[i] || (hi[i] - lo[i]) < MinSpan) begin
                lo[i] <= '0; hi[i] <= SampleMax; ce[i] <= CenterDef;
              end else if (smp_of(item, i) < lo[i]) ce[i] <= lo[i] + 10'd1;
              else if (smp_of(item, i) > hi[i]) ce[i] <= hi[i] - 10'd1;
              else ce[i] <= smp_of(item, i);
            end
            calibrating <= 1'b0;
          end else if (calibrating) begin
            for (int i = 0; i < AXES; i++) begin
              if (smp_of(item, i) < lo[i]) lo[i] <= smp_of(item, i);
              if (smp_of(item, i) > hi[i]) hi[i] <= smp_of(item, i);
            end
          end
          button_before <= item.button_pressed;
          ax <= '0;
          state <= S_MAP;
        end
        S_MAP: begin
          if (calibrating) begin
            dreq.num <= 18'(s) * 18'd255;
            dreq.den <= SampleMax;
          end else if (upper) begin
            dreq.num <= 18'(sc - cc) * 18'd127;
            dreq.den <= mx - cc;
          end else if (zero_seg) begin
            dreq.num <= '0;
            dreq.den <= 10'd1;
          end else begin
            dreq.num <= {1'b0, sc - mn, 7'd0};
            dreq.den <= cc - mn;
          end
          state <= S_MAPW;
        end
        S_MAPW: if (drsp.done) begin
          // add the trim, then 128 for the upper segment, with saturation
          if (tsum[9] && !(!calibrating && upper)) tgt <= '0;
          else begin
            tgt <= (!calibrating && upper) ?
                   ((tsum + 10'd128 > 10'd255) ? 9'd255 : 9'(tsum + 10'd128)) :
                   ((tsum > 10'd255) ? 9'd255 : tsum[8:0]);
            if (!calibrating && upper && tsum[9] && (tsum + 10'd128) > 10'd255
                && (tsum + 10'd128) < 10'd512)
              tgt <= 9'(tsum + 10'd128);
            if (!calibrating && upper && tsum[9] && (tsum + 10'd128) >= 10'd512)
              tgt <= '0;
          end
          state <= S_SMO;
        end
        S_SMO: begin
          dreq.num <= 18'(dlt);
          dreq.den <= 10'(smoothing) + 10'd1;
          negd <= tgt < {1'b0, lvl[ax]};
          state <= S_SMOW;
        end
        S_SMOW: if (drsp.done) begin
          lvl[ax] <= negd ? lvl[ax] - drsp.quot[7:0] : lvl[ax] + drsp.quot[7:0];
          if (int'(ax) == AXES - 1) state <= S_OUT;
          else begin
            ax <= ax + AxW'(1);
            state <= S_MAP;
          end
        end
        S_OUT: if (out_load) begin
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // output register: frees the working state as soon as the result is copied
  assign out_load = (state == S_OUT) && (!out_valid || out_ch.ready);

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (out_load) out_valid <= 1'b1;
    else if (out_ch.ready) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (out_load) out_data <= out_data_next;
  end

  always_comb begin
    out_data_next = '0;
    out_data_next.level_axis0 = lvl[0];
    if (AXES > 1) out_data_next.level_axis1 = lvl[(AXES > 1) ? 1 : 0];
    if (AXES > 2) out_data_next.level_axis2 = lvl[(AXES > 2) ? 2 : 0];
    if (AXES > 3) out_data_next.level_axis3 = lvl[(AXES > 3) ? 3 : 0];
    out_data_next.in_calibration = calibrating;
    out_data_next.save_pulse = save;
  end

  assign in_ch.ready = (state == S_IDLE);
  assign out_ch.valid = out_valid;
  assign out_ch.data = out_data;
endmodule
`default_nettype wire

/* hdl/scns_check.sv */
// Port-level checks for the stick calibration block, bound to the top level.
// Depends on stick_calibrate_normalize_smooth, the target of the bind.
`default_nettype none
module scns_check (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic in_cal,
  input wire logic save
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  a_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(in_cal) && $stable(save))
    else $error("result changed while stalled");
  a_one: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready) else $error("second request taken at once");
  a_save: assert property (@(posedge clk) disable iff (rst)
    out_valid && save |-> !in_cal) else $error("save while calibrating");
  a_rst: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result after reset");
endmodule

bind stick_calibrate_normalize_smooth scns_check u_check (
  .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .in_cal(out_ch.data.in_calibration), .save(out_ch.data.save_pulse));
`default_nettype wire
